@@ sv/lut_atan2_binary_angle_macros.svh @@
// Assertion macros for the lut_atan2_binary_angle block.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef LUT_ATAN2_BINARY_ANGLE_MACROS_SVH
`define LUT_ATAN2_BINARY_ANGLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define LA2BA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LA2BA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/la2ba_pkg.sv @@
// Package for the lut_atan2_binary_angle block: widths, control struct and
// the arctangent table. No dependencies.
package la2ba_pkg;

  localparam int IN_WIDTH_DEF = 24;
  localparam int RATIO_BITS   = 12;
  localparam int FRAC_W       = 5;
  localparam int IDX_W        = RATIO_BITS - FRAC_W;
  localparam int LUT_ENTRIES  = 130;
  localparam int LUT_AW       = 8;
  localparam int LUT_W        = 16;
  localparam int DIFF_W       = 9;
  localparam int PROD_W       = DIFF_W + FRAC_W;
  localparam int OCT_W        = 3;
  localparam int ANGLE_W      = 15;
  localparam int OCT_LSB      = ANGLE_W - OCT_W;

  typedef struct packed {
    logic             vld;
    logic [OCT_W-1:0] oct;
  } la2ba_ctl_t;

  // atan(k/128) scaled so that pi/4 = 0x8000
  localparam logic [LUT_W-1:0] ARC_TABLE [0:LUT_ENTRIES-1] = '{
    16'h0000,16'h0146,16'h028C,16'h03D2,16'h0517,16'h065D,16'h07A2,16'h08E7,
    16'h0A2C,16'h0B71,16'h0CB5,16'h0DF9,16'h0F3C,16'h107F,16'h11C1,16'h1303,
    16'h1444,16'h1585,16'h16C5,16'h1804,16'h1943,16'h1A80,16'h1BBD,16'h1CFA,
    16'h1E35,16'h1F6F,16'h20A9,16'h21E1,16'h2319,16'h2450,16'h2585,16'h26BA,
    16'h27ED,16'h291F,16'h2A50,16'h2B80,16'h2CAF,16'h2DDC,16'h2F08,16'h3033,
    16'h315D,16'h3285,16'h33AC,16'h34D2,16'h35F6,16'h3719,16'h383A,16'h395A,
    16'h3A78,16'h3B95,16'h3CB1,16'h3DCB,16'h3EE4,16'h3FFB,16'h4110,16'h4224,
    16'h4336,16'h4447,16'h4556,16'h4664,16'h4770,16'h487A,16'h4983,16'h4A8B,
    16'h4B90,16'h4C94,16'h4D96,16'h4E97,16'h4F96,16'h5093,16'h518F,16'h5289,
    16'h5382,16'h5478,16'h556E,16'h5661,16'h5753,16'h5843,16'h5932,16'h5A1E,
    16'h5B0A,16'h5BF3,16'h5CDB,16'h5DC1,16'h5EA6,16'h5F89,16'h606A,16'h614A,
    16'h6228,16'h6305,16'h63E0,16'h64B9,16'h6591,16'h6667,16'h673B,16'h680E,
    16'h68E0,16'h69B0,16'h6A7E,16'h6B4B,16'h6C16,16'h6CDF,16'h6DA8,16'h6E6E,
    16'h6F33,16'h6FF7,16'h70B9,16'h717A,16'h7239,16'h72F6,16'h73B3,16'h746D,
    16'h7527,16'h75DF,16'h7695,16'h774A,16'h77FE,16'h78B0,16'h7961,16'h7A10,
    16'h7ABF,16'h7B6B,16'h7C17,16'h7CC1,16'h7D6A,16'h7E11,16'h7EB7,16'h7F5C,
    16'h8000,16'h80A2
  };

endpackage

@@ sv/lut_atan2_binary_angle.sv @@
// Four-quadrant arctangent to a 15-bit binary angle (16384 = pi).
// Fold stages, divider row, then interpolation stages; one item per cycle.
// Depth set by the row of divider cells, one quotient bit each; busy stays low.
// Synchronous active-low reset clears the valid bits only; no other state.
// Depends on la2ba_pkg, la2ba_fold, la2ba_div_cell, la2ba_interp, macros header.
`include "lut_atan2_binary_angle_macros.svh"
module lut_atan2_binary_angle import la2ba_pkg::*; #(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [IN_WIDTH-1:0] in_coord_x,
  input  logic signed [IN_WIDTH-1:0] in_coord_y,
  output logic                       out_valid,
  output logic        [ANGLE_W-1:0]  out_angle
);

  localparam int XW  = IN_WIDTH + 1;
  localparam int LAT = RATIO_BITS + 4;

  la2ba_ctl_t            ctl_a [0:RATIO_BITS];
  logic [XW-1:0]         x_a   [0:RATIO_BITS];
  logic [XW-1:0]         r_a   [0:RATIO_BITS];
  logic [RATIO_BITS-1:0] q_a   [0:RATIO_BITS];

  assign busy = 1'b0;

  la2ba_fold #(.IN_WIDTH(IN_WIDTH)) u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (start & ~busy),
    .coord_x_i (in_coord_x),
    .coord_y_i (in_coord_y),
    .ctl_o     (ctl_a[0]),
    .x_o       (x_a[0]),
    .y_o       (r_a[0])
  );

  assign q_a[0] = '0;

  for (genvar i = 0; i < RATIO_BITS; i++) begin : g_cell
    la2ba_div_cell #(.XW(XW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_a[i]),
      .x_i   (x_a[i]),
      .r_i   (r_a[i]),
      .q_i   (q_a[i]),
      .ctl_o (ctl_a[i+1]),
      .x_o   (x_a[i+1]),
      .r_o   (r_a[i+1]),
      .q_o   (q_a[i+1])
    );
  end

  la2ba_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_a[RATIO_BITS]),
    .q_i     (q_a[RATIO_BITS]),
    .vld_o   (out_valid),
    .angle_o (out_angle)
  );

  `LA2BA_ASSERT_IMPL(a_result_has_item, out_valid, $past(start, LAT), "result without item")
  `LA2BA_ASSERT_IMPL(a_half_plane, out_valid && $past(in_coord_y != '0, LAT),
    out_angle[ANGLE_W-1] == $past(in_coord_y[IN_WIDTH-1], LAT),
    "angle half-plane does not match sign of y")
  `LA2BA_ASSERT_IMPL(a_pos_x_axis,
    out_valid && $past(in_coord_y == '0 && !in_coord_x[IN_WIDTH-1], LAT),
    out_angle == '0, "positive x axis must give zero angle")
  `LA2BA_ASSERT_NEXT(a_chain_valid, ctl_a[RATIO_BITS-1].vld, ctl_a[RATIO_BITS].vld,
    "item lost in divider row")

endmodule

@@ sv/la2ba_fold.sv @@
// Octant fold: two register stages that map (x, y) into the first octant.
// Depends on la2ba_pkg.
module la2ba_fold import la2ba_pkg::*; #(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  input  logic signed [IN_WIDTH-1:0] coord_x_i,
  input  logic signed [IN_WIDTH-1:0] coord_y_i,
  output la2ba_ctl_t                 ctl_o,
  output logic        [IN_WIDTH:0]   x_o,
  output logic        [IN_WIDTH:0]   y_o
);

  localparam int SW = IN_WIDTH + 2;

  logic signed [SW-1:0] xs, ys, x1, y1, nx1, x2_nxt, y2_nxt;
  logic                 neg, rot;
  logic signed [SW-1:0] a_x_r, a_y_r;
  logic                 a_vld_r, a_neg_r, a_rot_r, a_zero_r, a_xneg_r;
  logic signed [SW-1:0] x3, y3;
  logic                 dia;
  logic                 b_vld_r;
  logic [OCT_W-1:0]     b_oct_r;

  // stage A: sign fold, then quarter-turn fold
  always_comb begin
    xs     = SW'(coord_x_i);
    ys     = SW'(coord_y_i);
    neg    = ys[SW-1];
    x1     = neg ? -xs : xs;
    y1     = neg ? -ys : ys;
    nx1    = neg ? xs : -xs;
    rot    = x1[SW-1] | (x1 == '0);
    x2_nxt = rot ? y1 : x1;
    y2_nxt = rot ? nx1 : y1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    a_x_r    <= x2_nxt;
    a_y_r    <= y2_nxt;
    a_neg_r  <= neg;
    a_rot_r  <= rot;
    a_zero_r <= (ys == '0);
    a_xneg_r <= xs[SW-1];
  end

  // stage B: eighth-turn fold; y == 0 forced to ratio 0
  always_comb begin
    dia = (a_x_r <= a_y_r);
    x3  = dia ? a_x_r + a_y_r : a_x_r;
    y3  = dia ? a_y_r - a_x_r : a_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_zero_r) begin
      b_oct_r <= {a_xneg_r, 2'b00};
      x_o     <= (IN_WIDTH+1)'(1);
      y_o     <= '0;
    end else begin
      b_oct_r <= {a_neg_r, a_rot_r, dia};
      x_o     <= x3[IN_WIDTH:0];
      y_o     <= y3[IN_WIDTH:0];
    end
  end

  assign ctl_o.vld = b_vld_r;
  assign ctl_o.oct = b_oct_r;

endmodule

@@ sv/la2ba_div_cell.sv @@
// Divider cell: one restoring step, one quotient bit per cell.
// Depends on la2ba_pkg.
module la2ba_div_cell import la2ba_pkg::*; #(
  parameter int XW = IN_WIDTH_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  la2ba_ctl_t            ctl_i,
  input  logic [XW-1:0]         x_i,
  input  logic [XW-1:0]         r_i,
  input  logic [RATIO_BITS-1:0] q_i,
  output la2ba_ctl_t            ctl_o,
  output logic [XW-1:0]         x_o,
  output logic [XW-1:0]         r_o,
  output logic [RATIO_BITS-1:0] q_o
);

  logic [XW:0]           r2;
  logic                  ge;
  logic [XW-1:0]         r_nxt;
  logic [RATIO_BITS-1:0] q_nxt;
  logic                  vld_r;
  logic [OCT_W-1:0]      oct_r;
  logic [XW-1:0]         x_r, r_r;
  logic [RATIO_BITS-1:0] q_r;

  always_comb begin
    r2    = {r_i, 1'b0};
    ge    = (r2 >= {1'b0, x_i});
    r_nxt = ge ? XW'(r2 - {1'b0, x_i}) : XW'(r2);
    q_nxt = {q_i[RATIO_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    oct_r <= ctl_i.oct;
    x_r   <= x_i;
    r_r   <= r_nxt;
    q_r   <= q_nxt;
  end

  assign ctl_o.vld = vld_r;
  assign ctl_o.oct = oct_r;
  assign x_o       = x_r;
  assign r_o       = r_r;
  assign q_o       = q_r;

endmodule

@@ sv/la2ba_interp.sv @@
// Table lookup and linear interpolation, then octant offset; two stages.
// Depends on la2ba_pkg.
module la2ba_interp import la2ba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  la2ba_ctl_t            ctl_i,
  input  logic [RATIO_BITS-1:0] q_i,
  output logic                  vld_o,
  output logic [ANGLE_W-1:0]    angle_o
);

  logic [LUT_AW-1:0]  idx;
  logic [LUT_W-1:0]   fa, fb;
  logic               a_vld_r, b_vld_r;
  logic [OCT_W-1:0]   a_oct_r;
  logic [LUT_W-1:0]   a_fa_r;
  logic [DIFF_W-1:0]  a_diff_r;
  logic [FRAC_W-1:0]  a_frac_r;
  logic [PROD_W-1:0]  prod;
  logic [LUT_W-1:0]   interp;
  logic [ANGLE_W-1:0] angle_nxt, angle_r;

  always_comb begin
    idx = {1'b0, q_i[RATIO_BITS-1:FRAC_W]};
    fa  = ARC_TABLE[idx];
    fb  = ARC_TABLE[LUT_AW'(idx + LUT_AW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= ctl_i.vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_oct_r  <= ctl_i.oct;
    a_fa_r   <= fa;
    a_diff_r <= DIFF_W'(fb - fa);
    a_frac_r <= q_i[FRAC_W-1:0];
  end

  always_comb begin
    prod      = PROD_W'(a_diff_r) * PROD_W'(a_frac_r);
    interp    = a_fa_r + LUT_W'(prod >> FRAC_W);
    angle_nxt = {a_oct_r, OCT_LSB'(0)} + ANGLE_W'(interp[LUT_W-1:3]);
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign vld_o   = b_vld_r;
  assign angle_o = angle_r;

endmodule

@@ bench/lut_atan2_binary_angle_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for lut_atan2_binary_angle: directed and random coordinate
// pairs, an in-bench arctangent predictor and a strobe monitor with a watchdog.
// Depends on la2ba_pkg and the lut_atan2_binary_angle RTL.
module lut_atan2_binary_angle_test;
  import la2ba_pkg::*;

  localparam int COORD_W    = 24;
  localparam int RANDOM_N   = 1850;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYC   = 40;
  localparam int RATIO_SH   = 12;
  localparam int STEP_SH    = 5;
  localparam int HALF_TURN  = 16384;
  localparam int OCT_TURN   = 4096;
  localparam logic signed [COORD_W-1:0] XMAX = 24'h7FFFFF;
  localparam logic signed [COORD_W-1:0] XMIN = 24'h800000;

  localparam logic [15:0] ATAN_STEPS [0:129] = '{
    16'h0000,16'h0146,16'h028C,16'h03D2,16'h0517,16'h065D,16'h07A2,16'h08E7,
    16'h0A2C,16'h0B71,16'h0CB5,16'h0DF9,16'h0F3C,16'h107F,16'h11C1,16'h1303,
    16'h1444,16'h1585,16'h16C5,16'h1804,16'h1943,16'h1A80,16'h1BBD,16'h1CFA,
    16'h1E35,16'h1F6F,16'h20A9,16'h21E1,16'h2319,16'h2450,16'h2585,16'h26BA,
    16'h27ED,16'h291F,16'h2A50,16'h2B80,16'h2CAF,16'h2DDC,16'h2F08,16'h3033,
    16'h315D,16'h3285,16'h33AC,16'h34D2,16'h35F6,16'h3719,16'h383A,16'h395A,
    16'h3A78,16'h3B95,16'h3CB1,16'h3DCB,16'h3EE4,16'h3FFB,16'h4110,16'h4224,
    16'h4336,16'h4447,16'h4556,16'h4664,16'h4770,16'h487A,16'h4983,16'h4A8B,
    16'h4B90,16'h4C94,16'h4D96,16'h4E97,16'h4F96,16'h5093,16'h518F,16'h5289,
    16'h5382,16'h5478,16'h556E,16'h5661,16'h5753,16'h5843,16'h5932,16'h5A1E,
    16'h5B0A,16'h5BF3,16'h5CDB,16'h5DC1,16'h5EA6,16'h5F89,16'h606A,16'h614A,
    16'h6228,16'h6305,16'h63E0,16'h64B9,16'h6591,16'h6667,16'h673B,16'h680E,
    16'h68E0,16'h69B0,16'h6A7E,16'h6B4B,16'h6C16,16'h6CDF,16'h6DA8,16'h6E6E,
    16'h6F33,16'h6FF7,16'h70B9,16'h717A,16'h7239,16'h72F6,16'h73B3,16'h746D,
    16'h7527,16'h75DF,16'h7695,16'h774A,16'h77FE,16'h78B0,16'h7961,16'h7A10,
    16'h7ABF,16'h7B6B,16'h7C17,16'h7CC1,16'h7D6A,16'h7E11,16'h7EB7,16'h7F5C,
    16'h8000,16'h80A2
  };

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    bit                        drain;
  } coord_item_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [ANGLE_W-1:0] angle;
  } angle_exp_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic                      out_valid;
  logic        [ANGLE_W-1:0] out_angle;

  coord_item_t pending_q[$];
  angle_exp_t  angle_q[$];
  int          gap_left = 0;
  int          err_cnt = 0;
  int          idle_cycles = 0;

  lut_atan2_binary_angle #(
    .IN_WIDTH(COORD_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .out_valid  (out_valid),
    .out_angle  (out_angle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [ANGLE_W-1:0] binary_angle(logic signed [COORD_W-1:0] cx,
                                                      logic signed [COORD_W-1:0] cy);
    longint x, y, t, quo, frac, idx, lo, hi, lerp;
    int     oct;
    x = cx;
    y = cy;
    oct = 0;
    if (y == 0) return (x < 0) ? ANGLE_W'(HALF_TURN) : '0;
    if (y < 0) begin
      x = -x;
      y = -y;
      oct += 4;
    end
    if (x <= 0) begin
      t = x;
      x = y;
      y = -t;
      oct += 2;
    end
    if (x <= y) begin
      t = y - x;
      x = x + y;
      y = t;
      oct += 1;
    end
    quo  = ((y <<< RATIO_SH) / x) & ((64'sd1 <<< RATIO_SH) - 1);
    frac = quo & ((64'sd1 <<< STEP_SH) - 1);
    idx  = quo >>> STEP_SH;
    lo   = ATAN_STEPS[idx];
    hi   = ATAN_STEPS[idx + 1];
    lerp = lo + (((hi - lo) * frac) >>> STEP_SH);
    return ANGLE_W'((oct * OCT_TURN + lerp / 8) & ((1 << ANGLE_W) - 1));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // full-scale value, sometimes shrunk to a random magnitude
  function automatic logic signed [COORD_W-1:0] any_coord();
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom);
    if ($urandom_range(0, 3) == 0) v = v >>> $urandom_range(1, COORD_W - 1);
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] tiny_coord();
    return COORD_W'(int'($urandom_range(0, 32)) - 16);
  endfunction

  function automatic logic signed [COORD_W-1:0] corner_coord();
    case ($urandom_range(0, 4))
      0: return XMIN;
      1: return XMAX;
      2: return COORD_W'(-1);
      3: return COORD_W'(1);
      default: return '0;
    endcase
  endfunction

  task automatic push_pair(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                           bit drain = 1'b0);
    coord_item_t it;
    it.x = x;
    it.y = y;
    it.drain = drain;
    pending_q.push_back(it);
  endtask

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // driver: holds an item until start && !busy, then inserts the next gap
  always @(posedge clk) begin
    coord_item_t nxt;
    bit          take;
    angle_exp_t  e;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        e.x = in_coord_x;
        e.y = in_coord_y;
        e.angle = binary_angle(in_coord_x, in_coord_y);
        angle_q.push_back(e);
      end
      if (!start || take) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && angle_q.size() != 0)) begin
          nxt = pending_q.pop_front();
          in_coord_x <= nxt.x;
          in_coord_y <= nxt.y;
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    angle_exp_t e;
    if (rst_n && out_valid) begin
      if (angle_q.size() == 0) begin
        flag_mismatch($sformatf("angle %0d with no item outstanding", out_angle));
      end else begin
        e = angle_q.pop_front();
        if (out_angle !== e.angle)
          flag_mismatch($sformatf("x=%0d y=%0d: angle %0d, want %0d",
                                  e.x, e.y, out_angle, e.angle));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("lut_atan2_binary_angle regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic signed [COORD_W-1:0] a;
    int                        r;
    // axes, zero and the most negative value
    push_pair(0, 0);
    push_pair(5, 0);
    push_pair(-5, 0);
    push_pair(XMIN, 0);
    push_pair(XMAX, 0);
    push_pair(0, 5);
    push_pair(0, -5);
    push_pair(0, XMIN);
    push_pair(0, XMAX);
    // diagonals: one per quadrant
    push_pair(100, 100);
    push_pair(-100, 100);
    push_pair(-100, -100);
    push_pair(100, -100);
    // full-scale corners
    push_pair(XMIN, XMIN);
    push_pair(XMAX, XMAX);
    push_pair(XMIN, XMAX);
    push_pair(XMAX, XMIN);
    // steep and shallow, in octants 0, 1, 2, 4, 5 and 7
    push_pair(XMAX, 1);
    push_pair(1, XMAX);
    push_pair(-1, XMIN);
    push_pair(XMIN, -1);
    push_pair(-3, 7);
    push_pair(7, -3);
    // waits for the pipeline to empty before it goes
    push_pair(-7, -3, 1'b1);

    for (int i = 0; i < RANDOM_N; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        push_pair(any_coord(), any_coord(), i % 200 == 0);
      end else if (r < 50) begin
        push_pair(tiny_coord(), tiny_coord());
      end else if (r < 65) begin
        if ($urandom_range(0, 1)) push_pair(any_coord(), tiny_coord());
        else push_pair(tiny_coord(), any_coord());
      end else if (r < 80) begin
        a = any_coord();
        if ($urandom_range(0, 1)) push_pair(a, a + tiny_coord());
        else push_pair(a, -a + tiny_coord());
      end else if (r < 90) begin
        push_pair(corner_coord(), corner_coord());
      end else begin
        push_pair(corner_coord(), any_coord());
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_q.size() != 0 || start || angle_q.size() != 0);
    repeat (TAIL_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("lut_atan2_binary_angle regression: pass");
    end else begin
      $display("lut_atan2_binary_angle regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/la2ba_pkg.sv
sv/la2ba_fold.sv
sv/la2ba_div_cell.sv
sv/la2ba_interp.sv
sv/lut_atan2_binary_angle.sv
bench/lut_atan2_binary_angle_test.sv
